// File: rtl/dht_pkg.sv
// Package for the double-hashing hash table: sizes, codes, request and
// result types, and the sequencer states. No dependencies.
`default_nettype none

package dht_pkg;

    // Table geometry
    localparam int TABLE_SLOTS  = 11;
    localparam int STEP_MODULUS = 7;

    // Field widths
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 10;

    // Digit-serial reduction: the key is taken four bits at a time
    localparam int DIGIT_W     = 4;
    localparam int SHIFT_W     = 32;
    localparam int KEY_DIGITS  = SHIFT_W / DIGIT_W;
    localparam int SLOT_IDX_W  = $clog2(TABLE_SLOTS);
    localparam int STEP_REM_W  = $clog2(STEP_MODULUS);
    localparam int STEP_VAL_W  = $clog2(STEP_MODULUS + 1);
    localparam int STEP_DIGITS = (STEP_VAL_W + DIGIT_W - 1) / DIGIT_W;
    localparam int DCNT_W      = $clog2(KEY_DIGITS);
    localparam int CNT_W       = (SLOT_IDX_W > DCNT_W) ? SLOT_IDX_W : DCNT_W;

    // Request selector codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
    } t_res;

    // Control of the shared modular reduction unit
    typedef struct packed {
        logic               clear;
        logic               step;
        logic [DIGIT_W-1:0] digit;
    } t_mod_ctrl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_SETUP,
        S_STEP,
        S_ISSUE,
        S_PROBE
    } t_state;

endpackage

`default_nettype wire

// File: rtl/dht_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/dht_mod_unit.sv
// Shared digit-serial reduction unit: folds one four-bit digit per step into
// remainders modulo the slot count and modulo the step modulus. Uses dht_pkg.
`default_nettype none

module dht_mod_unit (
    input  wire logic                            i_clk,
    input  wire dht_pkg::t_mod_ctrl              i_ctrl,
    output logic      [dht_pkg::SLOT_IDX_W-1:0]  o_rem_n,
    output logic      [dht_pkg::STEP_REM_W-1:0]  o_rem_m
);
    import dht_pkg::*;

    localparam int NW = SLOT_IDX_W + DIGIT_W;
    localparam int MW = STEP_REM_W + DIGIT_W;
    localparam logic [NW-1:0] MOD_N = NW'(TABLE_SLOTS);
    localparam logic [MW-1:0] MOD_M = MW'(STEP_MODULUS);

    logic [SLOT_IDX_W-1:0] r_acc_n, n_acc_n;
    logic [STEP_REM_W-1:0] r_acc_m, n_acc_m;
    logic [NW-1:0]         w_vn;
    logic [MW-1:0]         w_vm;

    // acc*16 + digit is below 16 times the modulus, so subtracting 8, 4, 2
    // and 1 times the modulus where possible leaves the remainder.
    always_comb begin
        w_vn = {r_acc_n, i_ctrl.digit};
        w_vm = {r_acc_m, i_ctrl.digit};
        for (int k = DIGIT_W - 1; k >= 0; k--) begin
            if (w_vn >= (MOD_N << k)) begin
                w_vn = w_vn - (MOD_N << k);
            end
            if (w_vm >= (MOD_M << k)) begin
                w_vm = w_vm - (MOD_M << k);
            end
        end
        n_acc_n = r_acc_n;
        n_acc_m = r_acc_m;
        if (i_ctrl.clear) begin
            n_acc_n = '0;
            n_acc_m = '0;
        end else if (i_ctrl.step) begin
            n_acc_n = w_vn[SLOT_IDX_W-1:0];
            n_acc_m = w_vm[STEP_REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_n <= n_acc_n;
        r_acc_m <= n_acc_m;
    end

    assign o_rem_n = r_acc_n;
    assign o_rem_m = r_acc_m;

endmodule

`default_nettype wire

// File: rtl/double_hash_table_top.sv
// Channel   | Ports                  | Handshake
// ----------+------------------------+-----------------------------------------
// request   | start, busy, i_req     | taken at an edge with start high, busy low
// result    | o_valid, o_res         | one-cycle strobe, always taken
//
// A request runs from acceptance to the result strobe through these steps: the key's
// eight digits are folded through the shared reduction unit, the step is set up and
// reduced, the first read is issued, then one slot is probed per cycle (1 to
// TABLE_SLOTS probes) through the registered read port of the key RAM. A new request
// is not taken until the last one's result is shown.
// Busy rises at the accepting edge and falls at the edge that registers the
// result; the next request may be taken in the very cycle that the result is shown.
// Reset (synchronous, active low) empties every slot at once through the
// per-slot used flags; the key store itself is not cleared.
// The receiver cannot stall: each result is presented for exactly one cycle.
//
// Depends on dht_pkg, dht_ram and dht_mod_unit.
`default_nettype none

module double_hash_table_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire dht_pkg::t_req i_req,
    output logic               o_valid,
    output dht_pkg::t_res      o_res
);
    import dht_pkg::*;

    // Sequencer state and request registers
    t_state                  r_state, n_state;
    logic                    r_req_type, n_req_type;
    logic [KEY_W-1:0]        r_key, n_key;
    logic [SHIFT_W-1:0]      r_shift, n_shift;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [SLOT_IDX_W-1:0]   r_pos, n_pos;
    logic [TABLE_SLOTS-1:0]  r_used, n_used;
    t_res                    r_res, n_res;
    logic                    r_res_vld, n_res_vld;

    // Datapath wires
    t_mod_ctrl               w_ctrl;
    logic [SLOT_IDX_W-1:0]   w_rem_n;
    logic [STEP_REM_W-1:0]   w_rem_m;
    logic [STEP_VAL_W-1:0]   w_step_val;
    logic [SLOT_IDX_W:0]     w_sum;
    logic [SLOT_IDX_W-1:0]   w_next_pos;
    logic [SLOT_IDX_W-1:0]   w_raddr;
    logic [KEY_W-1:0]        w_rd_key;
    logic                    w_we;
    logic                    w_done;
    logic                    w_used;
    logic                    w_match;
    logic                    w_last;

    dht_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .o_rem_n (w_rem_n),
        .o_rem_m (w_rem_m)
    );

    dht_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_pos),
        .i_wdata (r_key),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_key)
    );

    // Once the second reduction has run, the unit holds the probe step
    // (modulo the slot count) in its slot-count lane until the sequencer returns to idle.
    assign w_step_val = STEP_VAL_W'(STEP_MODULUS) - STEP_VAL_W'(w_rem_m);
    assign w_sum      = {1'b0, r_pos} + {1'b0, w_rem_n};
    assign w_next_pos = (w_sum >= (SLOT_IDX_W + 1)'(TABLE_SLOTS))
                      ? SLOT_IDX_W'(w_sum - (SLOT_IDX_W + 1)'(TABLE_SLOTS))
                      : w_sum[SLOT_IDX_W-1:0];

    assign w_used  = r_used[r_pos];
    assign w_match = (w_rd_key == r_key);
    assign w_last  = (r_cnt == CNT_W'(TABLE_SLOTS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (r_cnt == CNT_W'(KEY_DIGITS - 1)) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                if (r_cnt == CNT_W'(STEP_DIGITS - 1)) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        n_req_type = r_req_type;
        n_key      = r_key;
        n_shift    = r_shift;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_used     = r_used;
        n_res      = r_res;
        n_res_vld  = 1'b0;
        w_ctrl     = '0;
        w_raddr    = r_pos;
        w_we       = 1'b0;
        w_done     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_ctrl.clear = 1'b1;
                if (start) begin
                    n_req_type = i_req.req_type;
                    n_key      = i_req.key;
                    n_shift    = SHIFT_W'(i_req.key);
                    n_cnt      = '0;
                end
            end
            S_HASH, S_STEP: begin
                w_ctrl.step  = 1'b1;
                w_ctrl.digit = r_shift[SHIFT_W-1 -: DIGIT_W];
                n_shift      = r_shift << DIGIT_W;
                n_cnt        = r_cnt + CNT_W'(1);
            end
            S_SETUP: begin
                // Home slot is ready; start reducing the step value.
                n_pos        = w_rem_n;
                n_shift      = SHIFT_W'(w_step_val) << (SHIFT_W - STEP_DIGITS * DIGIT_W);
                n_cnt        = '0;
                w_ctrl.clear = 1'b1;
            end
            S_ISSUE: begin
                n_cnt = '0;
            end
            S_PROBE: begin
                w_raddr = w_next_pos;
                n_pos   = w_next_pos;
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_req_type == REQ_INSERT) begin
                    priority if (!w_used) begin
                        w_we          = 1'b1;
                        n_used[r_pos] = 1'b1;
                        w_done        = 1'b1;
                        n_res.status  = ST_INSERTED;
                        n_res.slot    = SLOT_W'(r_pos);
                    end else if (w_last) begin
                        w_done       = 1'b1;
                        n_res.status = ST_FULL;
                        n_res.slot   = '0;
                    end
                end else begin
                    priority if (!w_used) begin
                        w_done       = 1'b1;
                        n_res.status = ST_NOT_FOUND;
                        n_res.slot   = '0;
                    end else if (w_match) begin
                        w_done       = 1'b1;
                        n_res.status = ST_FOUND;
                        n_res.slot   = SLOT_W'(r_pos);
                    end else if (w_last) begin
                        w_done       = 1'b1;
                        n_res.status = ST_NOT_FOUND;
                        n_res.slot   = '0;
                    end
                end
                n_res_vld = w_done;
            end
            default: begin
                w_ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_res_vld <= n_res_vld;
        end
        r_req_type <= n_req_type;
        r_key      <= n_key;
        r_shift    <= n_shift;
        r_cnt      <= n_cnt;
        r_pos      <= n_pos;
        r_res      <= n_res;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_res_vld;
    assign o_res   = r_res;

`ifndef SYNTH
    // A result is only ever produced by a request that was in progress.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a request in progress");

    // An accepted request makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start the sequencer");

    // Slots are never freed outside reset.
    a_used_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_used & $past(r_used)) == $past(r_used)))
        else $error("occupied slot became empty");

    // Only an insert request may report a key as inserted.
    a_inserted_is_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.status == ST_INSERTED)) |-> (r_req_type == REQ_INSERT))
        else $error("inserted status on a search request");
`endif

endmodule

`default_nettype wire
